// ----- rtl/bca_pkg.sv -----
// Package for the BCD accumulator ALU.
// Holds the digit count, opcode codes, compare codes and operand clean-up.
// No dependencies.
package bca_pkg;

  localparam int DIGITS = 16;
  localparam int ACC_W  = DIGITS * 4;
  localparam int OPD_W  = 64;
  localparam int CNT_W  = $clog2(DIGITS + 1);

  localparam logic [2:0] OP_LOAD = 3'd0;
  localparam logic [2:0] OP_ADD  = 3'd1;
  localparam logic [2:0] OP_SUB  = 3'd2;
  localparam logic [2:0] OP_CMP  = 3'd3;
  localparam logic [2:0] OP_SHL  = 3'd4;
  localparam logic [2:0] OP_SHR  = 3'd5;

  localparam logic signed [1:0] ORD_LESS    = -2'sd1;
  localparam logic signed [1:0] ORD_EQUAL   = 2'sd0;
  localparam logic signed [1:0] ORD_GREATER = 2'sd1;

  // Saturate non-decimal nibbles to nine and drop digits above DIGITS.
  function automatic logic [ACC_W-1:0] sat_operand(input logic [OPD_W-1:0] word);
    logic [ACC_W-1:0] res;
    logic [3:0]       nib;
    res = '0;
    for (int i = 0; i < DIGITS; i++) begin
      nib = word[4*i +: 4];
      res[4*i +: 4] = (nib > 4'd9) ? 4'd9 : nib;
    end
    return res;
  endfunction

endpackage

// ----- rtl/bcd_accumulator_alu.sv -----
// BCD accumulator ALU top level: digit-serial add/subtract/compare and digit shifter.
// Depends on bca_pkg.
//
// A DIGITS-digit decimal accumulator driven one transaction at a time. Load
// and the unused opcodes pass from idle through the done state to the output
// register. Add, subtract and compare run one decimal digit per cycle through
// a single shared digit adder/subtractor, least significant digit first;
// compare and the subtract underflow test both come from the final borrow of
// that pass, and compare also uses its nonzero flag. Shifts move one digit per
// cycle, min(shift_amount, DIGITS) digits in all. in_stall is high from
// acceptance until the result is loaded into the output register; a finished
// result waits, and the block takes no new transaction, while an earlier
// result is held by out_stall.
module bcd_accumulator_alu (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [2:0]                in_func,
  input  logic [bca_pkg::OPD_W-1:0] in_operand,
  input  logic [4:0]                in_shift_amount,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [63:0]               out_value,
  output logic signed [1:0]         out_order,
  output logic                      out_clamped
);
  import bca_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_ARITH, S_SHIFT, S_DONE} state_t;

  state_t            state_r, state_nxt;
  logic [2:0]        op_r, op_nxt;
  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic [ACC_W-1:0]  opd_r, opd_nxt;
  logic [ACC_W-1:0]  wrk_r, wrk_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              car_r, car_nxt;
  logic              nz_r, nz_nxt;
  logic signed [1:0] order_r, order_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [63:0]       out_value_r, out_value_nxt;
  logic              out_clamped_r, out_clamped_nxt;

  logic [3:0] dig_a, dig_b, dig_res;
  logic       dig_cout;
  logic [4:0] dig_sum, dig_sub;
  logic       accept, slot_free, clamp;

  assign accept    = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);

  // Shared digit unit.
  assign dig_a   = acc_r[3:0];
  assign dig_b   = opd_r[3:0];
  assign dig_sum = {1'b0, dig_a} + {1'b0, dig_b} + {4'd0, car_r};
  assign dig_sub = {1'b0, dig_b} + {4'd0, car_r};

  always_comb begin
    if (op_r == OP_ADD) begin
      dig_cout = (dig_sum > 5'd9);
      dig_res  = dig_cout ? 4'(dig_sum - 5'd10) : dig_sum[3:0];
    end else begin
      dig_cout = ({1'b0, dig_a} < dig_sub);
      dig_res  = dig_cout ? 4'({1'b0, dig_a} + 5'd10 - dig_sub)
                          : 4'({1'b0, dig_a} - dig_sub);
    end
  end

  always_comb begin
    state_nxt       = state_r;
    op_nxt          = op_r;
    acc_nxt         = acc_r;
    opd_nxt         = opd_r;
    wrk_nxt         = wrk_r;
    cnt_nxt         = cnt_r;
    car_nxt         = car_r;
    nz_nxt          = nz_r;
    order_nxt       = order_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_value_nxt   = out_value_r;
    out_clamped_nxt = out_clamped_r;
    clamp           = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt  = in_func;
          opd_nxt = sat_operand(in_operand);
          car_nxt = 1'b0;
          nz_nxt  = 1'b0;
          cnt_nxt = CNT_W'(DIGITS);
          case (in_func)
            OP_LOAD: begin
              acc_nxt   = sat_operand(in_operand);
              state_nxt = S_DONE;
            end
            OP_ADD, OP_SUB, OP_CMP: begin
              state_nxt = S_ARITH;
            end
            OP_SHL, OP_SHR: begin
              if (32'(in_shift_amount) < DIGITS) begin
                cnt_nxt = CNT_W'(in_shift_amount);
              end
              state_nxt = S_SHIFT;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_ARITH: begin
        acc_nxt = (acc_r >> 4) | (ACC_W'(acc_r[3:0]) << (ACC_W - 4));
        opd_nxt = opd_r >> 4;
        wrk_nxt = (wrk_r >> 4) | (ACC_W'(dig_res) << (ACC_W - 4));
        car_nxt = dig_cout;
        nz_nxt  = nz_r || (dig_res != 4'd0);
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          state_nxt = S_DONE;
        end
      end
      S_SHIFT: begin
        if (cnt_r == '0) begin
          state_nxt = S_DONE;
        end else begin
          acc_nxt = (op_r == OP_SHL) ? (acc_r << 4) : (acc_r >> 4);
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          case (op_r)
            OP_ADD: begin
              acc_nxt = wrk_r;
            end
            OP_SUB: begin
              clamp   = car_r;
              acc_nxt = car_r ? '0 : wrk_r;
            end
            OP_CMP: begin
              order_nxt = car_r ? ORD_LESS : (nz_r ? ORD_GREATER : ORD_EQUAL);
            end
            default: begin
            end
          endcase
          out_valid_nxt   = 1'b1;
          out_value_nxt   = 64'(acc_nxt);
          out_clamped_nxt = clamp;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      op_r          <= OP_LOAD;
      acc_r         <= '0;
      opd_r         <= '0;
      wrk_r         <= '0;
      cnt_r         <= '0;
      car_r         <= 1'b0;
      nz_r          <= 1'b0;
      order_r       <= ORD_EQUAL;
      out_valid_r   <= 1'b0;
      out_value_r   <= '0;
      out_clamped_r <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      op_r          <= op_nxt;
      acc_r         <= acc_nxt;
      opd_r         <= opd_nxt;
      wrk_r         <= wrk_nxt;
      cnt_r         <= cnt_nxt;
      car_r         <= car_nxt;
      nz_r          <= nz_nxt;
      order_r       <= order_nxt;
      out_valid_r   <= out_valid_nxt;
      out_value_r   <= out_value_nxt;
      out_clamped_r <= out_clamped_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_value   = out_value_r;
  assign out_order   = order_r;
  assign out_clamped = out_clamped_r;

endmodule

// ----- dv/bcd_accumulator_alu_test.sv -----
// Self-checking testbench for the BCD accumulator ALU: a directed table, then random traffic,
// checked against typed rows or a decimal accumulator predictor kept in step with accepts.
// Depends on bca_pkg and bcd_accumulator_alu.
`timescale 1ns / 100ps

module bcd_accumulator_alu_test;
  import bca_pkg::*;

  localparam logic [2:0] OP_NOP6 = 3'd6;
  localparam logic [2:0] OP_NOP7 = 3'd7;
  localparam int IDLE_PCT = 21;
  localparam int RANDOM_ITEMS = 600;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [63:0]       value;
    logic signed [1:0] order;
    logic              clamped;
  } bcd_result_t;

  typedef struct {
    logic [2:0]  func;
    logic [63:0] operand;
    logic [4:0]  amt;
    logic        typed;
    bcd_result_t result;
  } stim_row_t;

  logic              clk;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [2:0]        in_func = '0;
  logic [OPD_W-1:0]  in_operand = '0;
  logic [4:0]        in_shift_amount = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [63:0]       out_value;
  logic signed [1:0] out_order;
  logic              out_clamped;

  logic [ACC_W-1:0]  acc_word = '0;
  logic signed [1:0] held_order = ORD_EQUAL;
  bcd_result_t       due_results[$];
  bcd_result_t       due;
  stim_row_t         directed_rows[$];
  int                fail_count = 0;
  int                cycle_count = 0;
  logic              steady = 1'b0;

  bcd_accumulator_alu uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_func        (in_func),
    .in_operand     (in_operand),
    .in_shift_amount(in_shift_amount),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_value      (out_value),
    .out_order      (out_order),
    .out_clamped    (out_clamped)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [ACC_W-1:0] clip_nines(input logic [63:0] w);
    logic [ACC_W-1:0] d;
    logic [3:0]       nib;
    d = '0;
    for (int i = 0; i < DIGITS; i++) begin
      nib = w[4*i +: 4];
      d[4*i +: 4] = (nib >= 4'd10) ? 4'd9 : nib;
    end
    return d;
  endfunction

  function automatic bcd_result_t decimal_step(input logic [2:0] f, input logic [63:0] raw,
                                               input logic [4:0] amt);
    logic [ACC_W-1:0] opd;
    logic [4:0]       sum;
    logic             carry;
    bcd_result_t      r;
    opd = clip_nines(raw);
    r.clamped = 1'b0;
    carry = 1'b0;
    case (f)
      OP_LOAD: acc_word = opd;
      OP_ADD: begin
        for (int i = 0; i < DIGITS; i++) begin
          sum = {1'b0, acc_word[4*i +: 4]} + {1'b0, opd[4*i +: 4]} + {4'b0, carry};
          carry = (sum >= 5'd10);
          if (carry) sum = sum - 5'd10;
          acc_word[4*i +: 4] = sum[3:0];
        end
      end
      OP_SUB: begin
        if (acc_word < opd) begin
          acc_word = '0;
          r.clamped = 1'b1;
        end else begin
          for (int i = 0; i < DIGITS; i++) begin
            sum = {1'b0, acc_word[4*i +: 4]} + 5'd10 - {1'b0, opd[4*i +: 4]} - {4'b0, carry};
            carry = (sum < 5'd10);
            if (!carry) sum = sum - 5'd10;
            acc_word[4*i +: 4] = sum[3:0];
          end
        end
      end
      OP_CMP: held_order = (acc_word < opd) ? ORD_LESS :
                           (acc_word > opd) ? ORD_GREATER : ORD_EQUAL;
      OP_SHL: acc_word = (amt >= DIGITS) ? '0 : acc_word << (4 * amt);
      OP_SHR: acc_word = (amt >= DIGITS) ? '0 : acc_word >> (4 * amt);
      default: ;
    endcase
    r.value = acc_word;
    r.order = held_order;
    return r;
  endfunction

  function automatic logic [63:0] random_bcd();
    logic [63:0] w;
    int          n;
    w = '0;
    n = $urandom_range(1, DIGITS);
    for (int i = 0; i < n; i++) w[4*i +: 4] = 4'($urandom_range(0, 9));
    return w;
  endfunction

  task automatic add_row(input logic [2:0] f, input logic [63:0] opd, input logic [4:0] amt,
                         input logic typed, input logic [63:0] val,
                         input logic signed [1:0] ord, input logic clm);
    stim_row_t row;
    row.func = f;
    row.operand = opd;
    row.amt = amt;
    row.typed = typed;
    row.result = '{value: val, order: ord, clamped: clm};
    directed_rows.push_back(row);
  endtask

  task automatic issue(input logic [2:0] f, input logic [63:0] opd, input logic [4:0] amt,
                       input logic typed, input bcd_result_t typed_result);
    bcd_result_t predicted;
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= f;
    in_operand <= opd;
    in_shift_amount <= amt;
    do @(posedge clk); while (in_stall);
    predicted = decimal_step(f, opd, amt);
    due_results.push_back(typed ? typed_result : predicted);
  endtask

  task automatic drain_pause();
    in_valid <= 1'b0;
    @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (due_results.size() == 0) begin
        $display("%0t: unexpected transaction value %h order %0d clamped %b",
                 $time, out_value, out_order, out_clamped);
        fail_count++;
      end else begin
        due = due_results.pop_front();
        if (out_value !== due.value) begin
          $display("%0t: value expected %h actual %h", $time, due.value, out_value);
          fail_count++;
        end
        if (out_order !== due.order) begin
          $display("%0t: order expected %0d actual %0d", $time, due.order, out_order);
          fail_count++;
        end
        if (out_clamped !== due.clamped) begin
          $display("%0t: clamped expected %b actual %b", $time, due.clamped, out_clamped);
          fail_count++;
        end
      end
    end
    out_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int          r;
    int          drain;
    logic [2:0]  f;
    logic [63:0] opd;
    logic [4:0]  amt;

    add_row(OP_CMP,  64'h0, 5'd0, 1'b1, 64'h0, ORD_EQUAL, 1'b0);
    add_row(OP_LOAD, 64'hFFFF_FFFF_FFFF_FFFF, 5'd0, 1'b1, 64'h9999_9999_9999_9999, ORD_EQUAL,
            1'b0);
    add_row(OP_ADD,  64'h1, 5'd0, 1'b1, 64'h0, ORD_EQUAL, 1'b0);
    add_row(OP_LOAD, 64'h1234_5678_9012_3456, 5'd0, 1'b1, 64'h1234_5678_9012_3456, ORD_EQUAL,
            1'b0);
    add_row(OP_CMP,  64'h1234_5678_9012_3457, 5'd0, 1'b1, 64'h1234_5678_9012_3456, ORD_LESS,
            1'b0);
    add_row(OP_CMP,  64'h1234_5678_9012_3455, 5'd0, 1'b1, 64'h1234_5678_9012_3456, ORD_GREATER,
            1'b0);
    add_row(OP_CMP,  64'h1234_5678_9012_3456, 5'd0, 1'b1, 64'h1234_5678_9012_3456, ORD_EQUAL,
            1'b0);
    add_row(OP_SUB,  64'h9999_9999_9999_9999, 5'd0, 1'b1, 64'h0, ORD_EQUAL, 1'b1);
    add_row(OP_LOAD, 64'h5000_0000_0000_0000, 5'd0, 1'b1, 64'h5000_0000_0000_0000, ORD_EQUAL,
            1'b0);
    add_row(OP_SUB,  64'h1, 5'd0, 1'b1, 64'h4999_9999_9999_9999, ORD_EQUAL, 1'b0);
    add_row(OP_SUB,  64'h4999_9999_9999_9999, 5'd0, 1'b1, 64'h0, ORD_EQUAL, 1'b0);
    add_row(OP_LOAD, 64'hABCD_EF01_2345_6789, 5'd0, 1'b1, 64'h9999_9901_2345_6789, ORD_EQUAL,
            1'b0);
    add_row(OP_SHL,  64'h0, 5'd0, 1'b0, '0, ORD_EQUAL, 1'b0);
    add_row(OP_SHL,  64'h0, 5'd1, 1'b0, '0, ORD_EQUAL, 1'b0);
    add_row(OP_SHR,  64'h0, 5'd15, 1'b0, '0, ORD_EQUAL, 1'b0);
    add_row(OP_LOAD, 64'h8765_4321_0987_6543, 5'd0, 1'b0, '0, ORD_EQUAL, 1'b0);
    add_row(OP_SHL,  64'h0, 5'd16, 1'b1, 64'h0, ORD_EQUAL, 1'b0);
    add_row(OP_LOAD, 64'h1, 5'd0, 1'b0, '0, ORD_EQUAL, 1'b0);
    add_row(OP_SHL,  64'h0, 5'd15, 1'b0, '0, ORD_EQUAL, 1'b0);
    add_row(OP_SHR,  64'h0, 5'd31, 1'b1, 64'h0, ORD_EQUAL, 1'b0);
    add_row(OP_NOP6, 64'hFFFF_FFFF_FFFF_FFFF, 5'd31, 1'b1, 64'h0, ORD_EQUAL, 1'b0);
    add_row(OP_LOAD, 64'h9999_9999_9999_9999, 5'd0, 1'b0, '0, ORD_EQUAL, 1'b0);
    add_row(OP_ADD,  64'hFAFA_FAFA_FAFA_FAFA, 5'd0, 1'b0, '0, ORD_EQUAL, 1'b0);
    add_row(OP_NOP7, 64'h0, 5'd9, 1'b0, '0, ORD_EQUAL, 1'b0);
    add_row(OP_CMP,  64'hF000_0000_0000_0000, 5'd0, 1'b0, '0, ORD_EQUAL, 1'b0);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i])
      issue(directed_rows[i].func, directed_rows[i].operand, directed_rows[i].amt,
            directed_rows[i].typed, directed_rows[i].result);

    drain_pause();

    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      steady = (k >= 250 && k < 400);
      if (k == 450) drain_pause();
      r = $urandom_range(99);
      opd = ($urandom_range(9) == 0) ? {$urandom, $urandom} : random_bcd();
      amt = ($urandom_range(4) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(0, 16));
      if (r < 15) f = OP_LOAD;
      else if (r < 35) f = OP_ADD;
      else if (r < 55) f = OP_SUB;
      else if (r < 70) f = OP_CMP;
      else if (r < 82) f = OP_SHL;
      else if (r < 94) f = OP_SHR;
      else f = ($urandom_range(1) == 0) ? OP_NOP6 : OP_NOP7;
      if ((f == OP_CMP || f == OP_SUB) && $urandom_range(2) == 0) opd = acc_word;
      issue(f, opd, amt, 1'b0, '0);
    end

    in_valid <= 1'b0;
    @(posedge clk);
    drain = 0;
    while (due_results.size() != 0 && drain < 2000) begin
      @(posedge clk);
      drain++;
    end
    repeat (40) @(posedge clk);
    if (due_results.size() != 0) begin
      $display("%0t: %0d transactions never arrived", $time, due_results.size());
    end
    if (fail_count == 0 && due_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
